>>> sv/lcg_pkg.sv
// ----------------------------------------------------------------------------
// lcg_pkg
// Shared constants, types and register indexes of the lexicographic
// combination generator.
// ----------------------------------------------------------------------------
`default_nettype none

package lcg_pkg;

   localparam int unsigned MAX_LETTERS_DEF = 16;

   localparam int unsigned POS_W      = 4;
   localparam int unsigned SLOT_W     = 4;
   localparam int unsigned LETTER_W   = 7;
   localparam int unsigned CFG_W      = 5;
   localparam int unsigned LETTERS_W  = 40;
   localparam int unsigned OFF_W      = 5;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 40;
   localparam int unsigned SUM_W      = 6;

   localparam logic [LETTER_W-1:0] ASCII_A = 7'd97;
   localparam logic [OFF_W-1:0]    OFF_MAX = 5'd25;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SET_SIZE,
      CSR_CHOOSE_COUNT,
      CSR_LETTERS_LOW,
      CSR_LETTERS_HIGH
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_SCAN,
      ST_REFILL,
      ST_EMIT,
      ST_NONE
   } state_type;

   // Effective set size (already clamped) and combination length.
   typedef struct packed {
      logic [CFG_W-1:0] set_size;
      logic [CFG_W-1:0] choose_count;
   } cfg_type;

   // Result of the shared position unit.
   typedef struct packed {
      logic             grow;
      logic [POS_W-1:0] inc;
   } alu_res_type;

endpackage

`default_nettype wire

>>> sv/lcg_if.sv
// ----------------------------------------------------------------------------
// lcg_req_if / lcg_rsp_if
// Valid/ready channels of the combination generator: the request word and
// the letter word.
// ----------------------------------------------------------------------------
`default_nettype none

interface lcg_req_if;
   import lcg_pkg::*;

   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

interface lcg_rsp_if;
   import lcg_pkg::*;

   logic                valid;
   logic                ready;
   logic [LETTER_W-1:0] letter;
   logic [SLOT_W-1:0]   slot;
   logic                last_letter;
   logic                more_left;
   logic                exhausted;

   modport source (output valid, output letter, output slot, output last_letter,
                   output more_left, output exhausted, input ready);
   modport sink   (input valid, input letter, input slot, input last_letter,
                   input more_left, input exhausted, output ready);
endinterface

`default_nettype wire

>>> sv/lcg_csr.sv
// ----------------------------------------------------------------------------
// lcg_csr
// Configuration registers, set-size clamp and the letter lookup that turns a
// stored position into its ASCII code.
// ----------------------------------------------------------------------------
`default_nettype none

module lcg_csr #(
   parameter int unsigned MAX_LETTERS = lcg_pkg::MAX_LETTERS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_we,
   input  wire lcg_pkg::csr_index_type          csr_index,
   input  wire logic [lcg_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic [lcg_pkg::POS_W-1:0]       rd_pos,
   output lcg_pkg::cfg_type                     cfg,
   output logic [lcg_pkg::LETTER_W-1:0]         letter
);
   import lcg_pkg::*;

   logic [CFG_W-1:0]     set_size_ff;
   logic [CFG_W-1:0]     choose_count_ff;
   logic [LETTERS_W-1:0] letters_low_ff;
   logic [LETTERS_W-1:0] letters_high_ff;

   logic [LETTERS_W-1:0] sel_word;
   logic [OFF_W-1:0]     offset;

   always_ff @(posedge clock) begin
      if (reset) begin
         set_size_ff     <= CFG_W'(16);
         choose_count_ff <= CFG_W'(1);
         letters_low_ff  <= '0;
         letters_high_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SET_SIZE:     set_size_ff     <= csr_wdata[CFG_W-1:0];
            CSR_CHOOSE_COUNT: choose_count_ff <= csr_wdata[CFG_W-1:0];
            CSR_LETTERS_LOW:  letters_low_ff  <= csr_wdata[LETTERS_W-1:0];
            CSR_LETTERS_HIGH: letters_high_ff <= csr_wdata[LETTERS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.choose_count = choose_count_ff;
      if (set_size_ff > CFG_W'(MAX_LETTERS)) begin
         cfg.set_size = CFG_W'(MAX_LETTERS);
      end else begin
         cfg.set_size = set_size_ff;
      end
   end

   // Positions 8 and up live in the high register; offsets past z saturate.
   always_comb begin
      sel_word = rd_pos[POS_W-1] ? letters_high_ff : letters_low_ff;
      offset   = sel_word[OFF_W*rd_pos[POS_W-2:0] +: OFF_W];
      if (offset > OFF_MAX) begin
         offset = OFF_MAX;
      end
      letter = ASCII_A + LETTER_W'(offset);
   end

endmodule

`default_nettype wire

>>> sv/lcg_alu.sv
// ----------------------------------------------------------------------------
// lcg_alu
// Shared position unit: tests whether a position can still grow against its
// limit and forms the incremented position used for bump and refill.
// ----------------------------------------------------------------------------
`default_nettype none

module lcg_alu #(
   parameter int unsigned MAX_LETTERS = lcg_pkg::MAX_LETTERS_DEF,
   localparam int unsigned IDX_W = $clog2(MAX_LETTERS)
) (
   input  wire logic [lcg_pkg::POS_W-1:0] pos,
   input  wire logic [IDX_W-1:0]          index,
   input  wire lcg_pkg::cfg_type          cfg,
   output lcg_pkg::alu_res_type           res
);
   import lcg_pkg::*;

   logic [SUM_W-1:0] lhs;
   logic [SUM_W-1:0] rhs;

   // A position may grow while pos + k < n + index.
   always_comb begin
      lhs      = SUM_W'(pos) + SUM_W'(cfg.choose_count);
      rhs      = SUM_W'(cfg.set_size) + SUM_W'(index);
      res.grow = lhs < rhs;
      res.inc  = pos + POS_W'(1);
   end

endmodule

`default_nettype wire

>>> sv/lexicographic_combination_generator.sv
// ----------------------------------------------------------------------------
// lexicographic_combination_generator
// Walks through the k-of-n combinations of a configured letter set in
// lexicographic order, one combination per request.
//
// The csr_ port sets n, k and the sixteen five-bit letter offsets; write it
// only while the block is idle. Each word accepted on req_chan either
// advances the walk or, with restart set, starts again at positions 0..k-1.
// The block answers with k words on rsp_chan, one letter per word, the last
// word flagged and carrying more_left. With k of zero, k above n, or after
// the final combination, a single word flagged exhausted is sent instead.
// From the accepting edge a first request fills positions 0..k-1; a later
// one scans down from position k-1 and, when position i is the one that grows,
// refills the positions after it. Emission then sends k words at one word per
// cycle while the receiver takes them, and the block returns to idle. When
// exhausted, the single word is sent straight from idle or after a scan that finds nothing.
// req_chan.ready is high only while no request is in progress. A stalled
// receiver holds the word in the output register and pauses emission.
// Synchronous reset returns the registers to n = 16, k = 1, clears the
// positions and the walk state.
// ----------------------------------------------------------------------------
`default_nettype none

module lexicographic_combination_generator #(
   parameter int unsigned MAX_LETTERS = lcg_pkg::MAX_LETTERS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   lcg_req_if.sink                             req_chan,
   lcg_rsp_if.source                           rsp_chan,
   input  wire logic                           csr_we,
   input  wire lcg_pkg::csr_index_type         csr_index,
   input  wire logic [lcg_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import lcg_pkg::*;

   localparam int unsigned IDX_W = $clog2(MAX_LETTERS);

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             started_ff, started_in;
   logic             finished_ff, finished_in;
   logic             more_ff, more_in;
   logic [POS_W-1:0] pos_ff [MAX_LETTERS];

   logic             pos_we;
   logic [POS_W-1:0] pos_wdata;
   logic [IDX_W-1:0] rd_addr;
   logic [POS_W-1:0] rd_pos;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [LETTER_W-1:0] letter_ff, letter_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic                last_ff, last_in;
   logic                more_left_ff, more_left_in;
   logic                exhausted_ff, exhausted_in;

   cfg_type             cfg;
   alu_res_type         alu_res;
   logic [LETTER_W-1:0] letter_lut;

   logic accept;
   logic out_free;
   logic at_last;
   logic started_eff;
   logic finished_eff;
   logic no_combo;
   logic any_more;

   lcg_csr #(
      .MAX_LETTERS(MAX_LETTERS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rd_pos    (rd_pos),
      .cfg       (cfg),
      .letter    (letter_lut)
   );

   lcg_alu #(
      .MAX_LETTERS(MAX_LETTERS)
   ) u_alu (
      .pos   (rd_pos),
      .index (rd_addr),
      .cfg   (cfg),
      .res   (alu_res)
   );

   // Refill reads the left neighbor of the entry being written.
   assign rd_addr = (state_ff == ST_REFILL) ? idx_ff - IDX_W'(1) : idx_ff;
   assign rd_pos  = pos_ff[rd_addr];

   assign accept       = req_chan.valid && (state_ff == ST_IDLE);
   assign out_free     = !rsp_valid_ff || rsp_chan.ready;
   assign at_last      = (CFG_W'(idx_ff) + CFG_W'(1)) == cfg.choose_count;
   assign started_eff  = started_ff && !req_chan.restart;
   assign finished_eff = finished_ff && !req_chan.restart;
   assign no_combo     = (cfg.choose_count == '0) || (cfg.choose_count > cfg.set_size)
                         || finished_eff;
   assign any_more     = more_ff || alu_res.grow;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (no_combo) begin
                  state_in = ST_NONE;
               end else if (started_eff) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_FILL;
               end
            end
         end
         ST_FILL: begin
            if (at_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_SCAN: begin
            if (alu_res.grow) begin
               state_in = at_last ? ST_EMIT : ST_REFILL;
            end else if (idx_ff == '0) begin
               state_in = ST_NONE;
            end
         end
         ST_REFILL: begin
            if (at_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free && at_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_NONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      idx_in       = idx_ff;
      started_in   = started_ff;
      finished_in  = finished_ff;
      more_in      = more_ff;
      pos_we       = 1'b0;
      pos_wdata    = alu_res.inc;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      letter_in    = letter_ff;
      slot_in      = slot_ff;
      last_in      = last_ff;
      more_left_in = more_left_ff;
      exhausted_in = exhausted_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               started_in  = started_eff;
               finished_in = finished_eff;
               idx_in      = '0;
               if (!no_combo) begin
                  if (started_eff) begin
                     idx_in = IDX_W'(cfg.choose_count - CFG_W'(1));
                  end else begin
                     started_in = 1'b1;
                  end
               end
            end
         end
         ST_FILL: begin
            pos_we    = 1'b1;
            pos_wdata = POS_W'(idx_ff);
            more_in   = 1'b0;
            idx_in    = at_last ? '0 : idx_ff + IDX_W'(1);
         end
         ST_SCAN: begin
            more_in = 1'b0;
            if (alu_res.grow) begin
               pos_we = 1'b1;
               idx_in = at_last ? '0 : idx_ff + IDX_W'(1);
            end else if (idx_ff == '0) begin
               finished_in = 1'b1;
            end else begin
               idx_in = idx_ff - IDX_W'(1);
            end
         end
         ST_REFILL: begin
            pos_we  = 1'b1;
            more_in = 1'b0;
            idx_in  = at_last ? '0 : idx_ff + IDX_W'(1);
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               letter_in    = letter_lut;
               slot_in      = SLOT_W'(idx_ff);
               last_in      = at_last;
               more_left_in = at_last && any_more;
               exhausted_in = 1'b0;
               more_in      = any_more;
               if (at_last) begin
                  finished_in = !any_more;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end
         ST_NONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               letter_in    = '0;
               slot_in      = '0;
               last_in      = 1'b1;
               more_left_in = 1'b0;
               exhausted_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         started_ff   <= 1'b0;
         finished_ff  <= 1'b0;
         more_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         started_ff   <= started_in;
         finished_ff  <= finished_in;
         more_ff      <= more_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The walk may resume after k is raised, so untouched entries must read zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_LETTERS; i++) begin
            pos_ff[i] <= '0;
         end
      end else if (pos_we) begin
         pos_ff[idx_ff] <= pos_wdata;
      end
   end

   always_ff @(posedge clock) begin
      letter_ff    <= letter_in;
      slot_ff      <= slot_in;
      last_ff      <= last_in;
      more_left_ff <= more_left_in;
      exhausted_ff <= exhausted_in;
   end

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.letter      = letter_ff;
   assign rsp_chan.slot        = slot_ff;
   assign rsp_chan.last_letter = last_ff;
   assign rsp_chan.more_left   = more_left_ff;
   assign rsp_chan.exhausted   = exhausted_ff;

endmodule

`default_nettype wire

>>> bench/lexicographic_combination_generator_tb.sv
// ----------------------------------------------------------------------------
// lexicographic_combination_generator_tb
// Self-checking bench for the k-of-n combination generator. A short directed
// table covers reset values, zero and oversized k, the clamped set size,
// saturated letters, exhaustion and register changes in the middle of a walk.
// A random part follows with walks of random length under random settings.
// Every letter word is checked field by field against a behavioral model of
// the position walk, while both channel sides idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module lexicographic_combination_generator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lcg_pkg::*;

   localparam int unsigned PHASE_ITEMS  = 40;
   localparam int unsigned SETTLE_GAP   = 8;
   localparam int unsigned DRAIN_GAP    = 100;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned CYCLE_LIMIT  = 600000;
   localparam int unsigned REPORT_LIMIT = 10;

   typedef struct packed {
      logic [LETTER_W-1:0] letter;
      logic [SLOT_W-1:0]   slot;
      logic                last_letter;
      logic                more_left;
      logic                exhausted;
   } letter_word_type;

   typedef enum {
      ROW_WRITE,
      ROW_REQUEST,
      ROW_REQUEST_TYPED
   } row_kind_type;

   typedef struct {
      row_kind_type          kind;
      csr_index_type         index;
      logic [CSR_DATA_W-1:0] value;
      logic                  restart;
      letter_word_type       word;
   } stim_row_type;

   localparam letter_word_type EXHAUSTED_WORD = '{letter: '0, slot: '0, last_letter: 1'b1,
                                                  more_left: 1'b0, exhausted: 1'b1};
   localparam letter_word_type FIRST_A_WORD = '{letter: ASCII_A, slot: '0, last_letter: 1'b1,
                                                more_left: 1'b1, exhausted: 1'b0};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_we    = 1'b0;
   csr_index_type         csr_index = CSR_SET_SIZE;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   lcg_req_if req_chan ();
   lcg_rsp_if rsp_chan ();

   lexicographic_combination_generator DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Model copy of the registers and the walk.
   logic [CFG_W-1:0]     model_set_size;
   logic [CFG_W-1:0]     model_choose;
   logic [LETTERS_W-1:0] model_low;
   logic [LETTERS_W-1:0] model_high;
   logic [POS_W-1:0]     walk_pos [MAX_LETTERS_DEF];
   logic                 walk_started;
   logic                 walk_done;

   letter_word_type pending_words [$];
   letter_word_type fresh_words [$];
   stim_row_type    directed_rows [$];

   int unsigned failures     = 0;
   int unsigned cycle_count  = 0;
   int unsigned phase_items  = 0;
   int unsigned send_idle_pct = 16;
   int unsigned recv_idle_pct = 55;
   bit          hold_wanted  = 1'b0;
   logic        hold_done    = 1'b0;
   int unsigned hold_left    = 0;

   initial begin
      req_chan.valid   = 1'b0;
      req_chan.restart = 1'b0;
      rsp_chan.ready   = 1'b0;
   end

   function automatic logic [LETTER_W-1:0] letter_at(input logic [POS_W-1:0] p);
      int unsigned      idx;
      logic [OFF_W-1:0] off;
      idx = int'(p);
      if (idx < 8)
         off = model_low[OFF_W*idx +: OFF_W];
      else
         off = model_high[OFF_W*(idx-8) +: OFF_W];
      if (off > OFF_MAX)
         off = OFF_MAX;
      return ASCII_A + LETTER_W'(off);
   endfunction

   function automatic bit can_advance(input int i, input int n, input int k);
      return int'(walk_pos[i]) + k < n + i;
   endfunction

   // Advances the model walk by one request and leaves its words in fresh_words.
   function automatic void advance_walk(input logic restart);
      int              n;
      int              k;
      int              i;
      int              j;
      bit              found;
      bit              more;
      letter_word_type w;
      fresh_words.delete();
      n = int'(model_set_size);
      if (n > MAX_LETTERS_DEF)
         n = MAX_LETTERS_DEF;
      k = int'(model_choose);
      if (restart) begin
         walk_started = 1'b0;
         walk_done    = 1'b0;
      end
      if (k == 0 || k > n || walk_done) begin
         fresh_words = {fresh_words, EXHAUSTED_WORD};
         return;
      end
      if (!walk_started) begin
         for (i = 0; i < k; i++)
            walk_pos[i] = POS_W'(i);
         walk_started = 1'b1;
      end else begin
         found = 1'b0;
         i = k;
         while (i > 0 && !found) begin
            i--;
            if (can_advance(i, n, k))
               found = 1'b1;
         end
         if (!found) begin
            walk_done = 1'b1;
            fresh_words = {fresh_words, EXHAUSTED_WORD};
            return;
         end
         walk_pos[i] = walk_pos[i] + 1'b1;
         for (j = i + 1; j < k; j++)
            walk_pos[j] = walk_pos[j-1] + 1'b1;
      end
      more = 1'b0;
      for (i = 0; i < k; i++)
         if (can_advance(i, n, k))
            more = 1'b1;
      if (!more)
         walk_done = 1'b1;
      for (i = 0; i < k; i++) begin
         w.letter      = letter_at(walk_pos[i]);
         w.slot        = SLOT_W'(i);
         w.last_letter = (i + 1 == k);
         w.more_left   = (i + 1 == k) && more;
         w.exhausted   = 1'b0;
         fresh_words = {fresh_words, w};
      end
   endfunction

   function automatic void add_write(input csr_index_type index,
                                     input logic [CSR_DATA_W-1:0] value);
      stim_row_type row;
      row.kind    = ROW_WRITE;
      row.index   = index;
      row.value   = value;
      row.restart = 1'b0;
      row.word    = '0;
      directed_rows = {directed_rows, row};
   endfunction

   function automatic void add_request(input logic restart);
      stim_row_type row;
      row.kind    = ROW_REQUEST;
      row.index   = CSR_SET_SIZE;
      row.value   = '0;
      row.restart = restart;
      row.word    = '0;
      directed_rows = {directed_rows, row};
   endfunction

   function automatic void add_typed(input logic restart, input letter_word_type word);
      stim_row_type row;
      row.kind    = ROW_REQUEST_TYPED;
      row.index   = CSR_SET_SIZE;
      row.value   = '0;
      row.restart = restart;
      row.word    = word;
      directed_rows = {directed_rows, row};
   endfunction

   // Waits until every expected word has come back and the block is idle.
   task automatic settle_block();
      req_chan.valid <= 1'b0;
      while (pending_words.size() != 0)
         @(posedge clock);
      repeat (SETTLE_GAP) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type index,
                            input logic [CSR_DATA_W-1:0] value);
      settle_block();
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (index)
         CSR_SET_SIZE:     model_set_size = value[CFG_W-1:0];
         CSR_CHOOSE_COUNT: model_choose   = value[CFG_W-1:0];
         CSR_LETTERS_LOW:  model_low      = value[LETTERS_W-1:0];
         CSR_LETTERS_HIGH: model_high     = value[LETTERS_W-1:0];
         default: ;
      endcase
   endtask

   // Offers one request word; typed rows replace the model's single word.
   task automatic send_request(input logic restart, input bit typed,
                               input letter_word_type word);
      if ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct)
            @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.restart <= restart;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      advance_walk(restart);
      if (typed)
         pending_words = {pending_words, word};
      else
         pending_words = {pending_words, fresh_words};
      phase_items++;
   endtask

   task automatic pick_setting();
      int unsigned n;
      int unsigned k;
      int unsigned pick;
      pick = $urandom_range(15);
      if (pick == 0) begin
         n = $urandom_range(31, 17);
         k = $urandom_range(16, 1);
      end else if (pick == 1) begin
         n = $urandom_range(16, 0);
         k = $urandom_range(1) ? 0 : $urandom_range(31, n + 1);
      end else if (pick == 2) begin
         n = MAX_LETTERS_DEF;
         k = $urandom_range(1) ? $urandom_range(16, 14) : $urandom_range(2, 1);
      end else begin
         n = $urandom_range(8, 1);
         k = $urandom_range(n, 1);
      end
      write_reg(CSR_SET_SIZE, CSR_DATA_W'(n));
      write_reg(CSR_CHOOSE_COUNT, CSR_DATA_W'(k));
      if ($urandom_range(2) == 0) begin
         write_reg(CSR_LETTERS_LOW, CSR_DATA_W'({$urandom, $urandom}));
         write_reg(CSR_LETTERS_HIGH, CSR_DATA_W'({$urandom, $urandom}));
      end
   endtask

   // Mostly a walk from a restart; sometimes the walk simply carries on
   // under the new setting.
   task automatic run_walk();
      int unsigned len;
      bit          first_restart;
      first_restart = ($urandom_range(3) != 0);
      len = $urandom_range(14, 1);
      for (int unsigned j = 0; j < len; j++)
         send_request(j == 0 ? first_restart : ($urandom_range(11) == 0), 1'b0, '0);
   endtask

   always @(posedge clock) begin : take_letters
      letter_word_type got;
      letter_word_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = '{letter: rsp_chan.letter, slot: rsp_chan.slot,
                 last_letter: rsp_chan.last_letter, more_left: rsp_chan.more_left,
                 exhausted: rsp_chan.exhausted};
         if (pending_words.size() == 0) begin
            if (failures < REPORT_LIMIT)
               $display("unexpected word: letter %0d slot %0d last %0b more %0b exh %0b",
                        got.letter, got.slot, got.last_letter, got.more_left, got.exhausted);
            failures++;
         end else begin
            want = pending_words.pop_front();
            if (got.letter !== want.letter || got.slot !== want.slot ||
                got.last_letter !== want.last_letter || got.more_left !== want.more_left ||
                got.exhausted !== want.exhausted) begin
               if (failures < REPORT_LIMIT) begin
                  $write("word mismatch: expected letter %0d slot %0d last %0b more %0b ",
                         want.letter, want.slot, want.last_letter, want.more_left);
                  $write("exh %0b, ", want.exhausted);
                  $display("got letter %0d slot %0d last %0b more %0b exh %0b",
                           got.letter, got.slot, got.last_letter, got.more_left,
                           got.exhausted);
               end
               failures++;
            end
         end
      end
      if (hold_wanted && !hold_done) begin
         hold_done      <= 1'b1;
         hold_left      <= HOLD_CYCLES;
         rsp_chan.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left      <= hold_left - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      model_set_size = CFG_W'(16);
      model_choose   = CFG_W'(1);
      model_low      = '0;
      model_high     = '0;
      foreach (walk_pos[i])
         walk_pos[i] = '0;
      walk_started = 1'b0;
      walk_done    = 1'b0;

      // Reset values first, then zero k, a single full-length combination with
      // exhaustion that persists, k above n, clamped set size with saturated
      // letters, an empty set, and registers changed in the middle of a walk.
      add_typed(1'b0, FIRST_A_WORD);
      add_typed(1'b1, FIRST_A_WORD);
      add_write(CSR_CHOOSE_COUNT, CSR_DATA_W'(0));
      add_typed(1'b0, EXHAUSTED_WORD);
      add_write(CSR_CHOOSE_COUNT, CSR_DATA_W'(16));
      add_request(1'b1);
      add_typed(1'b0, EXHAUSTED_WORD);
      add_typed(1'b0, EXHAUSTED_WORD);
      add_write(CSR_CHOOSE_COUNT, CSR_DATA_W'(17));
      add_typed(1'b1, EXHAUSTED_WORD);
      add_write(CSR_LETTERS_LOW, 40'hFF_FFFF_FFFF);
      add_write(CSR_LETTERS_HIGH, 40'hC8_3A5B_19E7);
      add_write(CSR_SET_SIZE, CSR_DATA_W'(31));
      add_write(CSR_CHOOSE_COUNT, CSR_DATA_W'(15));
      add_request(1'b1);
      add_request(1'b0);
      add_request(1'b0);
      add_write(CSR_SET_SIZE, CSR_DATA_W'(0));
      add_typed(1'b1, EXHAUSTED_WORD);
      add_write(CSR_SET_SIZE, CSR_DATA_W'(1));
      add_write(CSR_CHOOSE_COUNT, CSR_DATA_W'(1));
      add_request(1'b1);
      add_typed(1'b0, EXHAUSTED_WORD);
      add_write(CSR_SET_SIZE, CSR_DATA_W'(5));
      add_write(CSR_CHOOSE_COUNT, CSR_DATA_W'(3));
      add_request(1'b1);
      add_request(1'b0);
      add_request(1'b0);
      add_write(CSR_CHOOSE_COUNT, CSR_DATA_W'(2));
      add_request(1'b0);
      add_write(CSR_SET_SIZE, CSR_DATA_W'(3));
      add_request(1'b0);
      add_request(1'b0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[r]) begin
         case (directed_rows[r].kind)
            ROW_WRITE:
               write_reg(directed_rows[r].index, directed_rows[r].value);
            ROW_REQUEST:
               send_request(directed_rows[r].restart, 1'b0, '0);
            default:
               send_request(directed_rows[r].restart, 1'b1, directed_rows[r].word);
         endcase
      end

      for (int phase = 0; phase < 3; phase++) begin
         phase_items = 0;
         if (phase == 1) begin
            send_idle_pct = 55;
            recv_idle_pct = 16;
         end else if (phase == 2) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         while (phase_items < PHASE_ITEMS) begin
            pick_setting();
            // With the receiver held off, the block fills its output and stops
            // taking request words while the sender keeps offering.
            if (phase == 2 && !hold_wanted)
               hold_wanted = 1'b1;
            run_walk();
         end
      end

      req_chan.valid <= 1'b0;
      while (pending_words.size() != 0)
         @(posedge clock);
      repeat (DRAIN_GAP) @(posedge clock);
      if (failures == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

`default_nettype wire
